FILE: hw/rtl/rrv_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the rotor vector rotation
package rrv_pkg;

	localparam int COORD_W  = 16;
	localparam int ROT_W    = 16;
	localparam int FRAC_W   = 14;
	localparam int P1_W     = COORD_W + ROT_W;
	localparam int Q_W      = P1_W + 1;
	localparam int P2_W     = Q_W + ROT_W;
	localparam int R_W      = P2_W + 1;
	localparam int SHIFT_W  = 2 * FRAC_W;
	localparam int RS_W     = R_W - SHIFT_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_XY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_XZ     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YZ     = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ROT_W-1:0]   rot_t;
	typedef logic signed [P1_W-1:0]    p1_t;
	typedef logic signed [Q_W-1:0]     q_t;
	typedef logic signed [P2_W-1:0]    p2_t;
	typedef logic signed [R_W-1:0]     r_t;
	typedef logic signed [RS_W-1:0]    rs_t;

	typedef struct packed {
		rot_t a;
		rot_t bxy;
		rot_t bxz;
		rot_t byz;
	} rotor_t;

	// intermediate vector and trivector term
	typedef struct packed {
		q_t q0;
		q_t q1;
		q_t q2;
		q_t t;
	} qvec_t;

	typedef struct packed {
		coord_t val;
		logic   clip;
	} sat_t;

	localparam rot_t ROT_ONE  = {{(ROT_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};
	localparam rot_t ROT_ZERO = '0;
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	// half an lsb of the final scale
	localparam r_t ROUND_C = {{(R_W-SHIFT_W){1'b0}}, 1'b1, {(SHIFT_W-1){1'b0}}};

	function automatic q_t sx_q(input p1_t v);
		return {{(Q_W-P1_W){v[P1_W-1]}}, v};
	endfunction

	function automatic r_t sx_r(input p2_t v);
		return {{(R_W-P2_W){v[P2_W-1]}}, v};
	endfunction

	// clamp to the coordinate range; fits when the top bits are all sign
	function automatic sat_t sat(input rs_t v);
		sat_t s;
		logic fits;
		fits = (&v[RS_W-1:COORD_W-1]) | ~(|v[RS_W-1:COORD_W-1]);
		s.clip = ~fits;
		if (fits) begin
			s.val = v[COORD_W-1:0];
		end else if (v[RS_W-1]) begin
			s.val = COORD_MIN;
		end else begin
			s.val = COORD_MAX;
		end
		return s;
	endfunction

endpackage

FILE: hw/rtl/rrv_vec_if.sv
`timescale 1ns / 1ps
// input vector channel
interface rrv_vec_if;
	logic            valid;
	logic            ready;
	rrv_pkg::coord_t vec_x;
	rrv_pkg::coord_t vec_y;
	rrv_pkg::coord_t vec_z;

	modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
	modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

FILE: hw/rtl/rrv_res_if.sv
`timescale 1ns / 1ps
// rotated vector result channel
interface rrv_res_if;
	logic            valid;
	logic            ready;
	rrv_pkg::coord_t out_x;
	rrv_pkg::coord_t out_y;
	rrv_pkg::coord_t out_z;
	logic            clipped;

	modport source (output valid, output out_x, output out_y, output out_z, output clipped,
		input ready);
	modport sink   (input valid, input out_x, input out_y, input out_z, input clipped,
		output ready);
endinterface

FILE: hw/rtl/rotor_rotate_vector.sv
`timescale 1ns / 1ps
// Rotates each 3D vector beat by the configured rotor (R x R~) and returns one result beat
// per input beat. The datapath is a five-stage pipeline: two multiplier banks of twelve
// products each, each followed by an adder stage, and a final round-and-saturate stage.
// One vector is taken every cycle while the output is not stalled. Stalls back up stage
// by stage, so an empty stage still takes a new beat while a finished result waits. The
// rotor is held in four Q1.14 registers (scalar, xy, xz, yz), reset to the identity, and
// must only be written while no beat is in flight; it is not normalised here, so a rotor
// of length other than one scales the result and clipped flags a result in which any
// component was saturated to the range limit.
module rotor_rotate_vector (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rrv_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rrv_pkg::ROT_W-1:0]     cfg_wdata,
	rrv_vec_if.sink                       vec,
	rrv_res_if.source                     res
);

	rrv_pkg::rotor_t rotor;
	rrv_pkg::qvec_t  q_data;
	logic            q_valid;
	logic            q_ready;

	rrv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.rotor     (rotor)
	);

	rrv_qstage u_qstage (
		.clk     (clk),
		.arst_n  (arst_n),
		.rotor   (rotor),
		.vec     (vec),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data)
	);

	rrv_rstage u_rstage (
		.clk     (clk),
		.arst_n  (arst_n),
		.rotor   (rotor),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_data  (q_data),
		.res     (res)
	);

	// input only backs up when every stage is full behind a stalled result
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vec.ready |-> (res.valid && !res.ready))
		else $error("input stalled with a bubble in the pipeline");

	// a clipped result holds some component at the range limit
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.clipped) |->
			(res.out_x == rrv_pkg::COORD_MAX || res.out_x == rrv_pkg::COORD_MIN ||
			 res.out_y == rrv_pkg::COORD_MAX || res.out_y == rrv_pkg::COORD_MIN ||
			 res.out_z == rrv_pkg::COORD_MAX || res.out_z == rrv_pkg::COORD_MIN))
		else $error("clipped set with no component at the limit");

	// identity rotor never clips
	a_identity_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && rotor.a == rrv_pkg::ROT_ONE && rotor.bxy == rrv_pkg::ROT_ZERO &&
		 rotor.bxz == rrv_pkg::ROT_ZERO && rotor.byz == rrv_pkg::ROT_ZERO) |-> !res.clipped)
		else $error("identity rotation clipped");

endmodule

FILE: hw/rtl/rrv_cfg.sv
`timescale 1ns / 1ps
// rotor configuration registers
module rrv_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rrv_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rrv_pkg::ROT_W-1:0]        cfg_wdata,
	output rrv_pkg::rotor_t                  rotor
);

	rrv_pkg::rotor_t rotor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_q.a   <= rrv_pkg::ROT_ONE;
			rotor_q.bxy <= rrv_pkg::ROT_ZERO;
			rotor_q.bxz <= rrv_pkg::ROT_ZERO;
			rotor_q.byz <= rrv_pkg::ROT_ZERO;
		end else if (cfg_we) begin
			case (cfg_idx)
				rrv_pkg::CFG_SCALAR: rotor_q.a   <= cfg_wdata;
				rrv_pkg::CFG_XY:     rotor_q.bxy <= cfg_wdata;
				rrv_pkg::CFG_XZ:     rotor_q.bxz <= cfg_wdata;
				rrv_pkg::CFG_YZ:     rotor_q.byz <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign rotor = rotor_q;

endmodule

FILE: hw/rtl/rrv_qstage.sv
`timescale 1ns / 1ps
// first half of the sandwich: q = R x and the trivector term, two stages
module rrv_qstage (
	input  logic            clk,
	input  logic            arst_n,
	input  rrv_pkg::rotor_t rotor,
	rrv_vec_if.sink         vec,
	output logic            q_valid,
	input  logic            q_ready,
	output rrv_pkg::qvec_t  q_data
);

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	// products of each component with each rotor part
	rrv_pkg::p1_t ax0_s1, ax1_s1, ax2_s1;
	rrv_pkg::p1_t x0xy_s1, x0xz_s1, x0yz_s1;
	rrv_pkg::p1_t x1xy_s1, x1xz_s1, x1yz_s1;
	rrv_pkg::p1_t x2xy_s1, x2xz_s1, x2yz_s1;
	rrv_pkg::qvec_t q_s2;

	assign en_s2 = !v_s2 || q_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign vec.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= vec.valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && vec.valid) begin
			ax0_s1  <= rotor.a   * vec.vec_x;
			ax1_s1  <= rotor.a   * vec.vec_y;
			ax2_s1  <= rotor.a   * vec.vec_z;
			x0xy_s1 <= rotor.bxy * vec.vec_x;
			x0xz_s1 <= rotor.bxz * vec.vec_x;
			x0yz_s1 <= rotor.byz * vec.vec_x;
			x1xy_s1 <= rotor.bxy * vec.vec_y;
			x1xz_s1 <= rotor.bxz * vec.vec_y;
			x1yz_s1 <= rotor.byz * vec.vec_y;
			x2xy_s1 <= rotor.bxy * vec.vec_z;
			x2xz_s1 <= rotor.bxz * vec.vec_z;
			x2yz_s1 <= rotor.byz * vec.vec_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			q_s2.q0 <= rrv_pkg::sx_q(ax0_s1) + rrv_pkg::sx_q(x1xy_s1) + rrv_pkg::sx_q(x2xz_s1);
			q_s2.q1 <= rrv_pkg::sx_q(ax1_s1) - rrv_pkg::sx_q(x0xy_s1) + rrv_pkg::sx_q(x2yz_s1);
			q_s2.q2 <= rrv_pkg::sx_q(ax2_s1) - rrv_pkg::sx_q(x0xz_s1) - rrv_pkg::sx_q(x1yz_s1);
			q_s2.t  <= rrv_pkg::sx_q(x1xz_s1) - rrv_pkg::sx_q(x0yz_s1) - rrv_pkg::sx_q(x2xy_s1);
		end
	end

	assign q_valid = v_s2;
	assign q_data  = q_s2;

endmodule

FILE: hw/rtl/rrv_rstage.sv
`timescale 1ns / 1ps
// second half of the sandwich: r = q R~, rounding and saturation, three stages
module rrv_rstage (
	input  logic            clk,
	input  logic            arst_n,
	input  rrv_pkg::rotor_t rotor,
	input  logic            q_valid,
	output logic            q_ready,
	input  rrv_pkg::qvec_t  q_data,
	rrv_res_if.source       res
);

	logic v_s3, v_s4, v_s5;
	logic en_s3, en_s4, en_s5;

	rrv_pkg::p2_t aq0_s3, aq1_s3, aq2_s3;
	rrv_pkg::p2_t q0xy_s3, q0xz_s3;
	rrv_pkg::p2_t q1xy_s3, q1yz_s3;
	rrv_pkg::p2_t q2xz_s3, q2yz_s3;
	rrv_pkg::p2_t txy_s3, txz_s3, tyz_s3;
	rrv_pkg::r_t  r0_s4, r1_s4, r2_s4;
	rrv_pkg::r_t  rr0, rr1, rr2;
	rrv_pkg::sat_t s0, s1, s2;
	rrv_pkg::coord_t x_s5, y_s5, z_s5;
	logic clip_s5;

	assign en_s5 = !v_s5 || res.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign q_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= q_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && q_valid) begin
			aq0_s3  <= q_data.q0 * rotor.a;
			aq1_s3  <= q_data.q1 * rotor.a;
			aq2_s3  <= q_data.q2 * rotor.a;
			q0xy_s3 <= q_data.q0 * rotor.bxy;
			q0xz_s3 <= q_data.q0 * rotor.bxz;
			q1xy_s3 <= q_data.q1 * rotor.bxy;
			q1yz_s3 <= q_data.q1 * rotor.byz;
			q2xz_s3 <= q_data.q2 * rotor.bxz;
			q2yz_s3 <= q_data.q2 * rotor.byz;
			txy_s3  <= q_data.t  * rotor.bxy;
			txz_s3  <= q_data.t  * rotor.bxz;
			tyz_s3  <= q_data.t  * rotor.byz;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			r0_s4 <= rrv_pkg::sx_r(aq0_s3) + rrv_pkg::sx_r(q1xy_s3)
				+ rrv_pkg::sx_r(q2xz_s3) - rrv_pkg::sx_r(tyz_s3);
			r1_s4 <= rrv_pkg::sx_r(aq1_s3) - rrv_pkg::sx_r(q0xy_s3)
				+ rrv_pkg::sx_r(txz_s3) + rrv_pkg::sx_r(q2yz_s3);
			r2_s4 <= rrv_pkg::sx_r(aq2_s3) - rrv_pkg::sx_r(txy_s3)
				- rrv_pkg::sx_r(q0xz_s3) - rrv_pkg::sx_r(q1yz_s3);
		end
	end

	// round half up, then drop the fraction bits
	always_comb begin
		rr0 = r0_s4 + rrv_pkg::ROUND_C;
		rr1 = r1_s4 + rrv_pkg::ROUND_C;
		rr2 = r2_s4 + rrv_pkg::ROUND_C;
		s0 = rrv_pkg::sat(rr0[rrv_pkg::R_W-1:rrv_pkg::SHIFT_W]);
		s1 = rrv_pkg::sat(rr1[rrv_pkg::R_W-1:rrv_pkg::SHIFT_W]);
		s2 = rrv_pkg::sat(rr2[rrv_pkg::R_W-1:rrv_pkg::SHIFT_W]);
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			x_s5    <= s0.val;
			y_s5    <= s1.val;
			z_s5    <= s2.val;
			clip_s5 <= s0.clip | s1.clip | s2.clip;
		end
	end

	assign res.valid   = v_s5;
	assign res.out_x   = x_s5;
	assign res.out_y   = y_s5;
	assign res.out_z   = z_s5;
	assign res.clipped = clip_s5;

endmodule
